[rtl/core/ekrp_pkg.sv]
// Shared constants, codes and controller/datapath handshake types of the key range partitioner.
package ekrp_pkg;

    localparam int KEY_W           = 16;
    localparam int ID_W            = 16;
    localparam int ST_W            = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int MAX_SERVERS_DEF = 16;
    // key range size min..max inclusive needs one bit more than a key
    localparam int RANGE_W         = KEY_W + 1;
    localparam int DIV_CNT_W       = $clog2(RANGE_W + 1);

    localparam logic OP_JOIN  = 1'b0;
    localparam logic OP_LEAVE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_KEY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_KEY = 1'd1;

    localparam logic [KEY_W-1:0] MIN_KEY_RST = 16'd0;
    localparam logic [KEY_W-1:0] MAX_KEY_RST = 16'd1000;

    // commands from controller to datapath
    typedef struct packed {
        logic            load_item;
        logic            rd_en;
        logic            rd_next;
        logic            idx_inc;
        logic            wr_shift;
        logic            append;
        logic            cnt_dec;
        logic            div_init;
        logic            div_step;
        logic            emit;
        logic            put_reject;
        logic            put_empty;
        logic [ST_W-1:0] rej_status;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic op;
        logic match;
        logic at_end;
        logic shift_end;
        logic full;
        logic empty;
        logic div_done;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

[rtl/core/ekrp_item_if.sv]
// Request channel: one join or leave request per handshake.
interface ekrp_item_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [ekrp_pkg::ID_W-1:0]   srv_id;

    modport source (output valid, output opcode, output srv_id, input ready);
    modport sink   (input valid, input opcode, input srv_id, output ready);
endinterface

[rtl/core/ekrp_result_if.sv]
// Result channel: one member assignment or status result per handshake.
interface ekrp_result_if;
    logic                        valid;
    logic                        ready;
    logic [ekrp_pkg::ST_W-1:0]   status;
    logic [ekrp_pkg::ID_W-1:0]   member_id;
    logic [ekrp_pkg::KEY_W-1:0]  lower_key;
    logic [ekrp_pkg::KEY_W-1:0]  upper_key;
    logic                        table_empty;
    logic                        last;

    modport source (output valid, output status, output member_id, output lower_key,
                    output upper_key, output table_empty, output last, input ready);
    modport sink   (input valid, input status, input member_id, input lower_key,
                    input upper_key, input table_empty, input last, output ready);
endinterface

[rtl/core/ekrp_cfg_if.sv]
// Configuration write channel: register index and write data.
interface ekrp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ekrp_pkg::CFG_IDX_W-1:0]  index;
    logic [ekrp_pkg::KEY_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/ekrp_ctrl.sv]
// Controller state machine: search, update, divide and emit sequencing.
module ekrp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ekrp_pkg::status_t sts,
    output ekrp_pkg::cmd_t    cmd
);
    import ekrp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_REJ   = 4'd3;
    localparam logic [3:0] S_SHRD  = 4'd4;
    localparam logic [3:0] S_SHWR  = 4'd5;
    localparam logic [3:0] S_DIVI  = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_EMPTY = 4'd8;
    localparam logic [3:0] S_EMRD  = 4'd9;
    localparam logic [3:0] S_EMOUT = 4'd10;

    logic [3:0]      state_reg, state_next;
    logic [ST_W-1:0] rej_reg, rej_next;

    // advance state, hold reject reason
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rej_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            rej_reg   <= rej_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rej_next       = rej_reg;
        cmd            = '0;
        cmd.rej_status = rej_reg;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_SRD;
                end
            end
            S_SRD:
            begin
                if (sts.at_end)
                begin
                    if (sts.op == OP_LEAVE)
                    begin
                        rej_next   = ST_ABSENT;
                        state_next = S_REJ;
                    end
                    else if (sts.full)
                    begin
                        rej_next   = ST_FULL;
                        state_next = S_REJ;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        state_next = S_DIVI;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (sts.match)
                begin
                    if (sts.op == OP_JOIN)
                    begin
                        rej_next   = ST_PRESENT;
                        state_next = S_REJ;
                    end
                    else
                    begin
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_REJ:
            begin
                if (sts.out_free)
                begin
                    cmd.put_reject = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SHRD:
            begin
                if (sts.shift_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DIVI;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SHRD;
            end
            S_DIVI:
            begin
                if (sts.empty)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIVS;
                end
            end
            S_DIVS:
            begin
                if (sts.div_done)
                begin
                    state_next = S_EMRD;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.put_empty = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EMOUT;
            end
            S_EMOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = sts.emit_last ? S_IDLE : S_EMRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/ekrp_dp.sv]
// Datapath: member memory, count, config registers, serial divider and result register.
module ekrp_dp #(
    parameter int MAX_SERVERS = ekrp_pkg::MAX_SERVERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ekrp_pkg::cmd_t                 cmd,
    output ekrp_pkg::status_t              sts,
    input  logic                           in_opcode,
    input  logic [ekrp_pkg::ID_W-1:0]      in_srv_id,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ekrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ekrp_pkg::KEY_W-1:0]     cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ekrp_pkg::ST_W-1:0]      out_status,
    output logic [ekrp_pkg::ID_W-1:0]      out_member_id,
    output logic [ekrp_pkg::KEY_W-1:0]     out_lower_key,
    output logic [ekrp_pkg::KEY_W-1:0]     out_upper_key,
    output logic                           out_table_empty,
    output logic                           out_last,
    output logic [$clog2(MAX_SERVERS+1)-1:0] count
);
    import ekrp_pkg::*;

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);

    logic [ID_W-1:0]      mem [MAX_SERVERS];
    logic [ID_W-1:0]      rdata_reg;
    logic [IW-1:0]        raddr;

    logic                 op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        count_reg;
    logic [KEY_W-1:0]     min_key_reg;
    logic [KEY_W-1:0]     max_key_reg;

    logic [RANGE_W-1:0]   quo_reg;
    logic [CW-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [KEY_W-1:0]     lower_reg;

    logic                 out_valid_reg;
    logic [ST_W-1:0]      status_reg;
    logic [ID_W-1:0]      member_id_reg;
    logic [KEY_W-1:0]     lower_key_reg;
    logic [KEY_W-1:0]     upper_key_reg;
    logic                 empty_reg;
    logic                 last_reg;

    logic [CW:0]          idx_p1;
    logic [KEY_W-1:0]     hi_key;
    logic [RANGE_W-1:0]   range_c;
    logic [CW:0]          trial;
    logic                 trial_ge;
    logic [KEY_W-1:0]     upper_c;

    assign idx_p1   = {1'b0, idx_reg} + (CW+1)'(1);
    assign raddr    = cmd.rd_next ? idx_p1[IW-1:0] : idx_reg[IW-1:0];
    assign hi_key   = (max_key_reg < min_key_reg) ? min_key_reg : max_key_reg;
    assign range_c  = {1'b0, hi_key} - {1'b0, min_key_reg} + RANGE_W'(1);
    assign trial    = {rem_reg, quo_reg[RANGE_W-1]};
    assign trial_ge = trial >= {1'b0, count_reg};
    assign upper_c  = lower_reg + quo_reg[KEY_W-1:0] - KEY_W'(1)
                      + {{(KEY_W-1){1'b0}}, rem_reg != '0};

    // status toward the controller
    always_comb
    begin
        sts.op        = op_reg;
        sts.match     = rdata_reg == id_reg;
        sts.at_end    = idx_reg == count_reg;
        sts.shift_end = idx_p1 >= {1'b0, count_reg};
        sts.full      = count_reg == CW'(MAX_SERVERS);
        sts.empty     = count_reg == '0;
        sts.div_done  = dcnt_reg == '0;
        sts.out_free  = !out_valid_reg || out_ready;
        sts.emit_last = idx_p1 == {1'b0, count_reg};
    end

    // member memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[count_reg[IW-1:0]] <= id_reg;
        end
        else if (cmd.wr_shift)
        begin
            mem[idx_reg[IW-1:0]] <= rdata_reg;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // capture request, walk index
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= in_opcode;
            id_reg <= in_srv_id;
        end
        if (cmd.load_item || cmd.div_init)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_p1[CW-1:0];
        end
    end

    // member count and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            min_key_reg <= MIN_KEY_RST;
            max_key_reg <= MAX_KEY_RST;
        end
        else
        begin
            if (cmd.append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MIN_KEY: min_key_reg <= cfg_data;
                    REG_MAX_KEY: max_key_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // restoring divider, one quotient bit per cycle; remainder then counts down extras
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            dcnt_reg <= DIV_CNT_W'(RANGE_W);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            quo_reg   <= range_c;
            rem_reg   <= '0;
            lower_reg <= min_key_reg;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[RANGE_W-2:0], trial_ge};
            rem_reg <= trial_ge ? CW'(trial - {1'b0, count_reg}) : trial[CW-1:0];
        end
        else if (cmd.emit)
        begin
            lower_reg <= upper_c + KEY_W'(1);
            if (rem_reg != '0)
            begin
                rem_reg <= rem_reg - CW'(1);
            end
        end
    end

    // result valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.put_reject || cmd.put_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg    <= ST_OK;
            member_id_reg <= rdata_reg;
            lower_key_reg <= lower_reg;
            upper_key_reg <= upper_c;
            empty_reg     <= 1'b0;
            last_reg      <= sts.emit_last;
        end
        else if (cmd.put_reject)
        begin
            status_reg    <= cmd.rej_status;
            member_id_reg <= id_reg;
            lower_key_reg <= '0;
            upper_key_reg <= '0;
            empty_reg     <= 1'b0;
            last_reg      <= 1'b1;
        end
        else if (cmd.put_empty)
        begin
            status_reg    <= ST_OK;
            member_id_reg <= '0;
            lower_key_reg <= '0;
            upper_key_reg <= '0;
            empty_reg     <= 1'b1;
            last_reg      <= 1'b1;
        end
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_member_id   = member_id_reg;
    assign out_lower_key   = lower_key_reg;
    assign out_upper_key   = upper_key_reg;
    assign out_table_empty = empty_reg;
    assign out_last        = last_reg;
    assign count           = count_reg;

endmodule

[rtl/core/even_key_range_partitioner.sv]
// Even key range partitioner: membership list with even split of a key range.
//
// Channels: item_in takes join/leave requests (opcode, srv_id); result_out
// gives one result per member after an accepted change (member_id and the
// inclusive key bounds), last set on the final one. A rejected request gives
// a single result carrying the reason; an emptied table gives a single result
// with table_empty set. cfg_wr writes min_key (index 0) and max_key (index 1);
// it is always ready; the user must write it only while no request is in
// progress, as the block does not enforce this. One request is handled at a
// time; item_in.ready is high only when idle. A request runs as a search
// through the member memory (one read port, registered data); then, on an
// accepted leave, a shift of the later entries down one place; then the
// serial divider (one quotient bit per cycle); then one result per member.
// A rejection skips the shift and the divider.
// A result waits in the output register while the receiver stalls; the
// controller holds the next result until that register frees up.
// Reset clears the member count and loads min_key 0 and max_key 1000.
module even_key_range_partitioner #(
    parameter int MAX_SERVERS = ekrp_pkg::MAX_SERVERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ekrp_item_if.sink     item_in,
    ekrp_result_if.source result_out,
    ekrp_cfg_if.sink      cfg_wr
);
    import ekrp_pkg::*;

    localparam int CW = $clog2(MAX_SERVERS + 1);

    cmd_t          cmd;
    status_t       sts;
    logic [CW-1:0] count;

    ekrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ekrp_dp #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_opcode       (item_in.opcode),
        .in_srv_id       (item_in.srv_id),
        .cfg_valid       (cfg_wr.valid),
        .cfg_ready       (cfg_wr.ready),
        .cfg_index       (cfg_wr.index),
        .cfg_data        (cfg_wr.data),
        .out_valid       (result_out.valid),
        .out_ready       (result_out.ready),
        .out_status      (result_out.status),
        .out_member_id   (result_out.member_id),
        .out_lower_key   (result_out.lower_key),
        .out_upper_key   (result_out.upper_key),
        .out_table_empty (result_out.table_empty),
        .out_last        (result_out.last),
        .count           (count)
    );

`ifndef SYNTH
    // member count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(MAX_SERVERS))
        else $error("member count exceeds table size");

    // a request in progress blocks the next one
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready) |=> !item_in.ready)
        else $error("request accepted while another is in progress");

    // a rejection is a single final result with table_empty clear
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.status != ST_OK) |->
        (result_out.last && !result_out.table_empty))
        else $error("malformed rejection result");

    // an empty-table result is final and names no member
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.table_empty) |->
        (result_out.last && result_out.member_id == '0 && result_out.status == ST_OK))
        else $error("malformed empty-table result");
`endif

endmodule
